@@ design/pst_pkg.sv @@
package pst_pkg;

  // Default sizing
  localparam int PST_DEPTH       = 64;
  localparam int PST_VALUE_WIDTH = 32;

  // Request codes; code 7 is unused and does nothing
  typedef enum logic [2:0] {
    REQ_INSERT_AT     = 3'd0,
    REQ_INSERT_SORTED = 3'd1,
    REQ_ERASE         = 3'd2,
    REQ_REMOVE_ALL    = 3'd3,
    REQ_GET           = 3'd4,
    REQ_SET           = 3'd5,
    REQ_FIND          = 3'd6
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Compare unit result: stored entry vs. request value
  typedef struct packed {
    logic eq;  // entry equals value
    logic lt;  // entry below value, signed
  } cmp_res_t;

endpackage

@@ design/pst_mem.sv @@
module pst_mem #(
  parameter int DEPTH       = pst_pkg::PST_DEPTH,
  parameter int VALUE_WIDTH = pst_pkg::PST_VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [VALUE_WIDTH-1:0]     wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [VALUE_WIDTH-1:0]     rdata
);

  // one write port, one registered read port; contents undefined until written
  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pst_cmp.sv @@
module pst_cmp #(
  parameter int VALUE_WIDTH = pst_pkg::PST_VALUE_WIDTH
) (
  input  logic [VALUE_WIDTH-1:0] entry,
  input  logic [VALUE_WIDTH-1:0] value,
  output pst_pkg::cmp_res_t      res
);
  import pst_pkg::*;

  always_comb begin
    res.eq = (entry == value);
    res.lt = ($signed(entry) < $signed(value));
  end

endmodule

@@ design/positional_sequence_table.sv @@
// Sequencing: range/full errors and the unused code go straight to DONE; set writes, get reads,
//   insert_at and erase shift the entries above the position, find / remove_all scan up to count
//   entries, insert_sorted scans then shifts; an output stall holds the result in DONE.
// Throughput: one request at a time; the next is taken once the result has moved to the output register.
// Reset (rst_n low, synchronous): list emptied, result valid cleared; entries not cleared.
module positional_sequence_table #(
  parameter int DEPTH       = pst_pkg::PST_DEPTH,
  parameter int VALUE_WIDTH = pst_pkg::PST_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_new_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [5:0]         out_result_position,
  output logic signed [31:0] out_result_value,
  output logic [6:0]         out_removed_count,
  output logic [6:0]         out_entry_count
);
  import pst_pkg::*;

  localparam int AW = $clog2(DEPTH);      // entry address
  localparam int CW = $clog2(DEPTH + 1);  // count, 0..DEPTH
  localparam int PW = (CW > 7) ? CW : 7;  // position range compare

  // Sequencer phases:
  //   SCAN     - ascending read sweep through the compare unit (find, sorted
  //              insert search, remove_all with in-place compaction)
  //   SHIFT_UP - descending copy entry[k] <- entry[k-1] to open a slot
  //   SHIFT_DN - ascending copy entry[k] <- entry[k+1] to close a gap
  //   READ / READ_WAIT - single get
  //   WRITE    - store the request value at pos_r
  //   DONE     - hand result to the output register when it is free
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_READ_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  req_type_t              op_r, op_nxt;
  req_type_t              in_req;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          ri_r, ri_nxt;        // next read index
  logic [CW-1:0]          wi_r, wi_nxt;        // compaction write index
  logic [CW-1:0]          removed_r, removed_nxt;
  status_t                status_r, status_nxt;
  logic [AW-1:0]          rpos_r, rpos_nxt;
  logic [VALUE_WIDTH-1:0] rval_r, rval_nxt;
  logic                   rd_vld_r, rd_vld_nxt; // read data arriving this cycle
  logic [AW-1:0]          rd_tag_r, rd_tag_nxt; // address of that read

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [5:0]             out_rpos_r, out_rpos_nxt;
  logic [31:0]            out_rval_r, out_rval_nxt;
  logic [6:0]             out_removed_r, out_removed_nxt;
  logic [6:0]             out_count_r, out_count_nxt;

  // memory port
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   rd_issue;

  cmp_res_t               cmp_res;

  logic                   in_acc;
  logic                   full;
  logic [PW-1:0]          pos_w;
  logic [PW-1:0]          cnt_w;
  logic                   scan_leave;

  assign in_req = req_type_t'(in_req_type);
  // request value narrowed or sign-extended to storage width
  assign in_val = VALUE_WIDTH'(in_new_value);
  assign pos_w  = PW'(in_position);
  assign cnt_w  = PW'(count_r);
  assign full   = (count_r == CW'(DEPTH));
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  pst_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // single shared comparator, always fed by the memory read data
  pst_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .entry (mem_rdata),
    .value (val_r),
    .res   (cmp_res)
  );

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    val_nxt         = val_r;
    pos_nxt         = pos_r;
    count_nxt       = count_r;
    ri_nxt          = ri_r;
    wi_nxt          = wi_r;
    removed_nxt     = removed_r;
    status_nxt      = status_r;
    rpos_nxt        = rpos_r;
    rval_nxt        = rval_r;
    out_status_nxt  = out_status_r;
    out_rpos_nxt    = out_rpos_r;
    out_rval_nxt    = out_rval_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    mem_we          = 1'b0;
    mem_waddr       = AW'(pos_r);
    mem_wdata       = val_r;
    mem_raddr       = AW'(pos_r);
    rd_issue        = 1'b0;
    scan_leave      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_req;
          val_nxt     = in_val;
          pos_nxt     = CW'(in_position);
          status_nxt  = ST_OK;
          rpos_nxt    = '0;
          rval_nxt    = '0;
          removed_nxt = '0;
          ri_nxt      = '0;
          wi_nxt      = '0;
          state_nxt   = S_DONE;
          unique case (in_req) inside
            REQ_INSERT_AT: begin
              if (pos_w > cnt_w) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ri_nxt    = count_r;
                state_nxt = S_SHIFT_UP;
              end
            end
            REQ_INSERT_SORTED: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_ERASE: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ST_RANGE;
              end else begin
                ri_nxt    = CW'(pos_w + PW'(1));
                state_nxt = S_SHIFT_DN;
              end
            end
            REQ_REMOVE_ALL, REQ_FIND: begin
              state_nxt = S_SCAN;
            end
            REQ_GET: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_READ;
              end
            end
            REQ_SET: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_WRITE;
              end
            end
            default: begin
              state_nxt = S_DONE;  // unused code: no-op
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_issue  = (ri_r < count_r);
        mem_raddr = AW'(ri_r);
        if (rd_issue) begin
          ri_nxt = ri_r + CW'(1);
        end
        if (rd_vld_r) begin
          case (op_r)
            REQ_FIND: begin
              if (cmp_res.eq) begin
                rpos_nxt   = rd_tag_r;
                scan_leave = 1'b1;
                state_nxt  = S_DONE;
              end
            end
            REQ_INSERT_SORTED: begin
              // first entry not below the value
              if (!cmp_res.lt) begin
                pos_nxt    = CW'(rd_tag_r);
                ri_nxt     = count_r;
                scan_leave = 1'b1;
                state_nxt  = S_SHIFT_UP;
              end
            end
            default: begin
              // remove_all: keep non-matching entries, packed down behind the read
              if (cmp_res.eq) begin
                removed_nxt = removed_r + CW'(1);
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(wi_r);
                mem_wdata = mem_rdata;
                wi_nxt    = wi_r + CW'(1);
              end
            end
          endcase
        end
        // sweep exhausted, last read data handled above
        if (!scan_leave && (ri_r == count_r)) begin
          scan_leave = 1'b1;
          case (op_r)
            REQ_FIND: begin
              status_nxt = ST_MISS;
              state_nxt  = S_DONE;
            end
            REQ_INSERT_SORTED: begin
              pos_nxt   = count_r;
              ri_nxt    = count_r;
              state_nxt = S_SHIFT_UP;
            end
            default: begin
              count_nxt = wi_nxt;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // read k-1 now, write it to k next cycle
        rd_issue  = (ri_r > pos_r);
        mem_raddr = AW'(ri_r - CW'(1));
        if (rd_issue) begin
          ri_nxt = ri_r - CW'(1);
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag_r + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (ri_r == pos_r) begin
          state_nxt = S_WRITE;
        end
      end

      S_SHIFT_DN: begin
        // read k+1 now, write it to k next cycle
        rd_issue  = (ri_r < count_r);
        mem_raddr = AW'(ri_r);
        if (rd_issue) begin
          ri_nxt = ri_r + CW'(1);
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (ri_r == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_READ: begin
        rd_issue  = 1'b1;
        mem_raddr = AW'(pos_r);
        state_nxt = S_READ_WAIT;
      end

      S_READ_WAIT: begin
        rval_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = val_r;
        if (op_r != REQ_SET) begin
          count_nxt = count_r + CW'(1);
        end
        if (op_r == REQ_INSERT_SORTED) begin
          rpos_nxt = AW'(pos_r);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // output register free or being drained this cycle
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_rpos_nxt    = 6'(rpos_r);
          out_rval_nxt    = 32'(rval_r);
          out_removed_nxt = 7'(removed_r);
          out_count_nxt   = 7'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = rd_issue && !scan_leave;
  assign rd_tag_nxt = mem_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    pos_r         <= pos_nxt;
    ri_r          <= ri_nxt;
    wi_r          <= wi_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    rpos_r        <= rpos_nxt;
    rval_r        <= rval_nxt;
    rd_tag_r      <= rd_tag_nxt;
    out_status_r  <= out_status_nxt;
    out_rpos_r    <= out_rpos_nxt;
    out_rval_r    <= out_rval_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_position = out_rpos_r;
  assign out_result_value    = out_rval_r;
  assign out_removed_count   = out_removed_r;
  assign out_entry_count     = out_count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && rd_issue |-> mem_waddr != mem_raddr)
    else $error("shift copy reads and writes one address");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && op_r == REQ_REMOVE_ALL |-> wi_r <= ri_r)
    else $error("compaction write overtook the read sweep");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> count_r == $past(count_r))
    else $error("count changed without a request in work");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && out_stall |=> state_r == S_DONE)
    else $error("result dropped while output register full");
`endif

endmodule

@@ tb/sv/pst_checker.sv @@
module pst_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [6:0]        in_position,
  input  logic [31:0]       in_new_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic [5:0]        out_result_position,
  input  logic [31:0]       out_result_value,
  input  logic [6:0]        out_removed_count,
  input  logic [6:0]        out_entry_count,
  output int                fail_count,
  output int                outstanding,
  output int                list_size
);
  import pst_pkg::*;

  localparam int DEPTH = PST_DEPTH;

  typedef struct packed {
    status_t            status;
    logic [5:0]         position;
    logic signed [31:0] value;
    logic [6:0]         removed;
    logic [6:0]         held;
  } list_result_t;

  // predicted list contents
  logic [31:0] slot_value [DEPTH];
  int          slot_count;

  list_result_t expected_results [$];
  int           mismatch_count;
  int           result_no;

  // open a slot at pos and store val there
  function automatic void place_entry(int pos, logic [31:0] val);
    for (int k = slot_count; k > pos; k--) slot_value[k] = slot_value[k-1];
    slot_value[pos] = val;
    slot_count++;
  endfunction

  function automatic list_result_t apply_request(logic [2:0] req, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int           k;
    int           w;
    int           removed;
    r        = '0;
    r.status = ST_OK;
    case (req)
      REQ_INSERT_AT: begin
        if (int'(pos) > slot_count) r.status = ST_RANGE;
        else if (slot_count >= DEPTH) r.status = ST_FULL;
        else place_entry(int'(pos), val);
      end
      REQ_INSERT_SORTED: begin
        if (slot_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          k = 0;
          while (k < slot_count && $signed(val) > $signed(slot_value[k])) k++;
          place_entry(k, val);
          r.position = 6'(k);
        end
      end
      REQ_ERASE: begin
        if (int'(pos) >= slot_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = int'(pos); k + 1 < slot_count; k++) slot_value[k] = slot_value[k+1];
          slot_count--;
        end
      end
      REQ_REMOVE_ALL: begin
        w       = 0;
        removed = 0;
        for (k = 0; k < slot_count; k++) begin
          if (slot_value[k] == val) begin
            removed++;
          end else begin
            slot_value[w] = slot_value[k];
            w++;
          end
        end
        slot_count = w;
        r.removed  = 7'(removed);
      end
      REQ_GET: begin
        if (int'(pos) >= slot_count) r.status = ST_RANGE;
        else r.value = slot_value[pos];
      end
      REQ_SET: begin
        if (int'(pos) >= slot_count) r.status = ST_RANGE;
        else slot_value[pos] = val;
      end
      REQ_FIND: begin
        k = 0;
        while (k < slot_count && slot_value[k] != val) k++;
        if (k < slot_count) r.position = 6'(k);
        else r.status = ST_MISS;
      end
      default: ;
    endcase
    r.held = 7'(slot_count);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t seen;
    list_result_t want;
    if (!rst_n) begin
      slot_count = 0;
      expected_results.delete();
    end else begin
      // retire the result first: it always belongs to an earlier request
      if (out_valid && !out_stall) begin
        seen.status   = status_t'(out_status);
        seen.position = out_result_position;
        seen.value    = out_result_value;
        seen.removed  = out_removed_count;
        seen.held     = out_entry_count;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d with no request pending: status %0d pos %0d value %0d",
                     result_no, seen.status, seen.position, seen.value);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d mismatch: exp status %0d pos %0d value %0d removed %0d",
                        " count %0d / got status %0d pos %0d value %0d removed %0d count %0d"},
                       result_no, want.status, want.position, want.value, want.removed,
                       want.held, seen.status, seen.position, seen.value, seen.removed,
                       seen.held);
          end
        end
        result_no++;
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(in_req_type, in_position, in_new_value));
    end
    fail_count  <= mismatch_count;
    outstanding <= expected_results.size();
    list_size   <= slot_count;
  end

endmodule

@@ tb/sv/tb_positional_sequence_table.sv @@
module tb_positional_sequence_table;
  import pst_pkg::*;

  localparam int          DEPTH          = PST_DEPTH;
  localparam int          RANDOM_ITEMS   = 650;
  localparam int          WATCHDOG_LIMIT = 4000;
  // code 7 is not an operation; the block must treat it as a no-op
  localparam logic [2:0]  REQ_UNUSED     = 3'd7;
  localparam logic [31:0] VAL_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN        = 32'h8000_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [6:0]  in_position = '0;
  logic [31:0] in_new_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_result_position;
  logic [31:0] out_result_value;
  logic [6:0]  out_removed_count;
  logic [6:0]  out_entry_count;

  int fail_count;
  int outstanding;
  int list_size;

  // idle percentages for the sender and the receiver, changed per phase
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_sequence_table u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_position         (in_position),
    .in_new_value        (in_new_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_position (out_result_position),
    .out_result_value    (out_result_value),
    .out_removed_count   (out_removed_count),
    .out_entry_count     (out_entry_count)
  );

  pst_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_position         (in_position),
    .in_new_value        (in_new_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_position (out_result_position),
    .out_result_value    (out_result_value),
    .out_removed_count   (out_removed_count),
    .out_entry_count     (out_entry_count),
    .fail_count          (fail_count),
    .outstanding         (outstanding),
    .list_size           (list_size)
  );

  // result side: random back-pressure, independent of anything else
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, with an optional random idle gap first, and hold it
  // until the block takes it. Called at a rising edge; returns at the edge
  // where the request was accepted.
  task automatic send_request(input logic [2:0] req, input logic [6:0] pos,
                              input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_position  <= pos;
    in_new_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Values mostly from a small pool so that find and remove_all hit, and
  // duplicates pile up; the rest the two extremes or fully random to toggle every bit.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 32'(int'($urandom_range(8)) - 4);
      5:             return VAL_MAX;
      6:             return VAL_MIN;
      default:       return $urandom;
    endcase
  endfunction

  // Mostly legal positions (0..count, count itself included for insert_at),
  // sometimes anything the 7-bit field holds.
  function automatic logic [6:0] pick_position(int held);
    if ($urandom_range(9) < 8) return 7'($urandom_range(held, 0));
    return 7'($urandom_range(127));
  endfunction

  initial begin
    int          n;
    int          roll;
    bit          growing;
    logic [2:0]  req;

    growing = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation but the sorted insert on an empty list, then extremes
    // of values and positions, unused code, duplicates and range errors
    send_request(REQ_GET,           7'd0,   32'd0);
    send_request(REQ_ERASE,         7'd0,   32'd0);
    send_request(REQ_SET,           7'd0,   32'd9);
    send_request(REQ_FIND,          7'd0,   32'd0);       // missed find
    send_request(REQ_REMOVE_ALL,    7'd0,   32'd5);       // remove with no match
    send_request(REQ_UNUSED,        7'd127, 32'hFFFF_FFFF);
    send_request(REQ_INSERT_AT,     7'd1,   32'd1);       // position past count
    send_request(REQ_INSERT_AT,     7'd0,   VAL_MAX);
    send_request(REQ_INSERT_AT,     7'd1,   VAL_MIN);     // position equal to count
    send_request(REQ_INSERT_AT,     7'd127, 32'd3);
    send_request(REQ_INSERT_SORTED, 7'd0,   32'hFFFF_FFFF);
    send_request(REQ_INSERT_SORTED, 7'd0,   VAL_MIN);
    send_request(REQ_INSERT_SORTED, 7'd0,   VAL_MAX);
    send_request(REQ_INSERT_SORTED, 7'd0,   32'd0);
    send_request(REQ_FIND,          7'd0,   VAL_MAX);
    send_request(REQ_FIND,          7'd0,   32'd12345);
    send_request(REQ_GET,           7'd0,   32'd0);
    send_request(REQ_GET,           7'd5,   32'd0);       // last entry
    send_request(REQ_GET,           7'd6,   32'd0);       // one past the end
    send_request(REQ_SET,           7'd2,   VAL_MAX);
    send_request(REQ_REMOVE_ALL,    7'd0,   VAL_MAX);     // several copies
    send_request(REQ_ERASE,         7'd0,   32'd0);
    send_request(REQ_ERASE,         7'd64,  32'd0);
    send_request(REQ_GET,           7'd0,   32'd0);

    // random: alternate between filling the list up to full (plus a few
    // rejected inserts) and draining it, so shifts run over every length
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / (RANDOM_ITEMS / 4 + 1))
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 78; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase

      // list_size lags one request behind; good enough for steering
      if (list_size <= 2) growing = 1'b1;
      else if (list_size >= DEPTH && $urandom_range(3) == 0) growing = 1'b0;

      roll = $urandom_range(99);
      if (growing) begin
        if (roll < 30)      req = REQ_INSERT_AT;
        else if (roll < 65) req = REQ_INSERT_SORTED;
        else if (roll < 72) req = REQ_ERASE;
        else if (roll < 76) req = REQ_REMOVE_ALL;
        else if (roll < 84) req = REQ_GET;
        else if (roll < 90) req = REQ_SET;
        else if (roll < 98) req = REQ_FIND;
        else                req = REQ_UNUSED;
      end else begin
        if (roll < 8)       req = REQ_INSERT_AT;
        else if (roll < 16) req = REQ_INSERT_SORTED;
        else if (roll < 46) req = REQ_ERASE;
        else if (roll < 58) req = REQ_REMOVE_ALL;
        else if (roll < 72) req = REQ_GET;
        else if (roll < 80) req = REQ_SET;
        else if (roll < 98) req = REQ_FIND;
        else                req = REQ_UNUSED;
      end
      send_request(req, pick_position(list_size), pick_value());
    end

    in_valid <= 1'b0;
    // one edge so the checker has logged the last request
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // drain time: longest operation is a sorted insert on a list one short of full
    repeat (150) @(posedge clk);

    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
